// ----- design/mmre_pkg.sv -----
package mmre_pkg;

    // Sizing
    localparam int MAX_DIM    = 16;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    localparam int DIM_LIM  = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam int OUT_BITS = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
    localparam int K_W      = $clog2(DIM_LIM);
    localparam int AW       = $clog2(MAX_DIM * MAX_DIM);
    localparam int PROD_W   = 2 * DATA_WIDTH;
    localparam int ACC_W    = PROD_W + K_W + 1;
    localparam int RND_W    = ACC_W + 1;

    // Fixed field widths
    localparam int DIM_W      = 5;
    localparam int IDX_W      = 4;
    localparam int VAL_W      = 16;
    localparam int FUNC_W     = 2;
    localparam int REG_ADDR_W = 4;
    localparam int APB_DW     = 32;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [ACC_W-1:0]      t_acc;
    typedef logic signed [VAL_W-1:0]      t_val;
    typedef logic [K_W-1:0]               t_k;
    typedef logic [DIM_W-1:0]             t_dim;
    typedef logic [IDX_W-1:0]             t_idx;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_OUT
    } t_state;

    // One step of the inner product travelling down the cell chain
    typedef struct packed {
        logic  vld;
        logic  first;
        logic  last;
        logic  nul;
        t_k    k;
        t_data a;
    } t_tok;

    typedef struct packed {
        logic clr;
        logic shift;
        logic bwe;
    } t_cell_ctl;

    localparam longint DATA_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam longint DATA_LO = -DATA_HI - 64'sd1;

    localparam logic signed [RND_W-1:0] RND_BIAS =
        RND_W'((64'sd1 <<< FRAC_BITS) >>> 1);
    localparam logic signed [RND_W-1:0] OUT_HI =
        RND_W'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [RND_W-1:0] OUT_LO = -OUT_HI - RND_W'(1);

    function automatic t_dim eff_dim(input t_dim v);
        t_dim r;
        if (v > t_dim'(DIM_LIM)) r = t_dim'(DIM_LIM);
        else r = v;
        return r;
    endfunction

    function automatic t_data sat_in(input t_val v);
        longint x;
        x = longint'(v);
        if (x > DATA_HI) x = DATA_HI;
        else if (x < DATA_LO) x = DATA_LO;
        return t_data'(x);
    endfunction

    // Round half up, floor shift, saturate
    function automatic t_val round_sat(input t_acc acc);
        logic signed [RND_W-1:0] s;
        s = (RND_W'(acc) + RND_BIAS) >>> FRAC_BITS;
        if (s > OUT_HI) s = OUT_HI;
        else if (s < OUT_LO) s = OUT_LO;
        return t_val'(s);
    endfunction

endpackage

// ----- design/mmre_mac_cell.sv -----
module mmre_mac_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mmre_pkg::t_cell_ctl i_ctl,
    input  mmre_pkg::t_k        i_bk,
    input  mmre_pkg::t_data     i_bdata,
    input  mmre_pkg::t_tok      i_tok,
    output mmre_pkg::t_tok      o_tok,
    input  mmre_pkg::t_val      i_res,
    output mmre_pkg::t_val      o_res,
    output logic                o_done
);
    import mmre_pkg::*;

    t_data r_bcol [DIM_LIM];
    t_tok  r_tok;
    t_prod r_prod;
    logic  r_pv;
    logic  r_pf;
    logic  r_pl;
    t_acc  r_acc;
    logic  r_fin;
    t_val  r_res;
    logic  r_done;

    // Column of B owned by this cell
    always_ff @(posedge i_clk) begin
        if (i_ctl.bwe) begin
            r_bcol[i_bk] <= i_bdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
            r_pv      <= 1'b0;
            r_fin     <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_pv  <= r_tok.vld;
            r_pf  <= r_tok.first;
            r_pl  <= r_tok.last;
            r_prod <= r_tok.nul ? '0
                                : t_prod'(r_tok.a) * t_prod'(r_bcol[r_tok.k]);
            if (r_pv) begin
                r_acc <= r_pf ? t_acc'(r_prod) : r_acc + t_acc'(r_prod);
            end
            r_fin <= r_pv & r_pl;
            if (i_ctl.clr) begin
                r_done <= 1'b0;
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
            if (i_ctl.shift) begin
                r_res <= i_res;
            end else if (r_fin) begin
                r_res <= round_sat(r_acc);
            end
        end
    end

    assign o_tok  = r_tok;
    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

// ----- design/matrix_multiply_row_engine.sv -----
// Dense matrix multiply, C = A x B, signed fixed point, one result row per request.
//
// Request channel (i_in_valid / o_in_stall): func 0 loads A[row][col], func 1 loads
// B[row][col], func 2 computes row 'row' of C. Loads outside the configured sizes are
// dropped, as are compute requests for a row at or beyond rows_a and unknown codes.
// The block handles one request at a time and holds o_in_stall high until a compute
// request has delivered its whole row.
//
// Result channel (o_out_valid / i_out_stall): a compute request yields cols_b results in
// increasing column order, o_out_last on the final one. After the request is taken, A is
// read once per inner-product step from its store and that element walks along a chain
// of 16 MAC cells, one cell per result column, each holding its column of B. Results then
// leave one per cycle from the head of the chain; while i_out_stall is high the current
// result is held and the chain does not shift.
//
// Configuration: APB registers rows_a (0x0), inner_dim (0x4), cols_b (0x8), reset 16.
// Write them only while idle. Reset returns the control to idle; the A and B stores are
// not cleared and must be loaded before use.
module matrix_multiply_row_engine (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // request channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [mmre_pkg::FUNC_W-1:0]            i_func,
    input  mmre_pkg::t_idx                         i_row,
    input  mmre_pkg::t_idx                         i_col,
    input  mmre_pkg::t_val                         i_value,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output mmre_pkg::t_idx                         o_out_row,
    output mmre_pkg::t_idx                         o_out_col,
    output mmre_pkg::t_val                         o_out_value,
    output logic                                   o_out_last,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [mmre_pkg::REG_ADDR_W-1:0]        paddr,
    input  logic [mmre_pkg::APB_DW-1:0]            pwdata,
    output logic [mmre_pkg::APB_DW-1:0]            prdata,
    output logic                                   pready
);
    import mmre_pkg::*;

    // configuration registers
    t_dim   r_rows_a;
    t_dim   r_inner_dim;
    t_dim   r_cols_b;
    logic   w_cfg_wr;
    t_reg   w_cfg_idx;

    // effective sizes
    t_dim   w_nr;
    t_dim   w_nk;
    t_dim   w_nc;

    // sequencer
    t_state r_state, n_state;
    t_k     r_k, n_k;
    t_idx   r_j, n_j;
    t_idx   r_row, n_row;
    logic   r_nul, n_nul;
    logic   w_in_acc;
    logic   w_out_acc;
    logic   w_start;
    logic   w_awe;
    logic   w_bld;
    logic   w_issue;
    logic   w_klast;
    logic   w_all_done;
    t_data  w_sat_val;

    // A store and token issue stage
    t_data         r_amem [MAX_DIM * MAX_DIM];
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    t_data         r_aq;
    logic          r_tv;
    logic          r_tf;
    logic          r_tl;
    logic          r_tn;
    t_k            r_tk;

    // cell chain
    t_tok      w_tok_in  [DIM_LIM];
    t_tok      w_tok_out [DIM_LIM];
    t_val      w_res_in  [DIM_LIM];
    t_val      w_res_out [DIM_LIM];
    logic [DIM_LIM-1:0] w_done;
    t_cell_ctl w_ctl     [DIM_LIM];

    // ---------------------------------------------------------------- configuration
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = t_reg'(paddr[REG_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= t_dim'(16);
            r_inner_dim <= t_dim'(16);
            r_cols_b    <= t_dim'(16);
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_ROWS_A:    r_rows_a    <= pwdata[DIM_W-1:0];
                REG_INNER_DIM: r_inner_dim <= pwdata[DIM_W-1:0];
                REG_COLS_B:    r_cols_b    <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_cfg_idx)
            REG_ROWS_A:    prdata = {{(APB_DW - DIM_W){1'b0}}, r_rows_a};
            REG_INNER_DIM: prdata = {{(APB_DW - DIM_W){1'b0}}, r_inner_dim};
            REG_COLS_B:    prdata = {{(APB_DW - DIM_W){1'b0}}, r_cols_b};
            default:       prdata = '0;
        endcase
    end

    assign w_nr = eff_dim(r_rows_a);
    assign w_nk = eff_dim(r_inner_dim);
    assign w_nc = eff_dim(r_cols_b);

    // ---------------------------------------------------------------- handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid & ~o_in_stall;
    assign o_out_valid = (r_state == ST_OUT);
    assign w_out_acc   = o_out_valid & ~i_out_stall;

    assign w_sat_val  = sat_in(i_value);
    assign w_klast    = r_nul || (t_dim'(r_k) == w_nk - t_dim'(1));
    assign w_all_done = &w_done;

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_j     <= '0;
            r_row   <= '0;
            r_nul   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_j     <= n_j;
            r_row   <= n_row;
            r_nul   <= n_nul;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_j     = r_j;
        n_row   = r_row;
        n_nul   = r_nul;
        w_start = 1'b0;
        w_awe   = 1'b0;
        w_bld   = 1'b0;
        w_issue = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (t_func'(i_func))
                        FUNC_LOAD_A: begin
                            w_awe = (t_dim'(i_row) < w_nr) && (t_dim'(i_col) < w_nk);
                        end
                        FUNC_LOAD_B: begin
                            w_bld = (t_dim'(i_row) < w_nk) && (t_dim'(i_col) < w_nc);
                        end
                        FUNC_COMPUTE: begin
                            // drop rows out of range and empty result rows
                            if ((t_dim'(i_row) < w_nr) && (w_nc != '0)) begin
                                w_start = 1'b1;
                                n_state = ST_RUN;
                                n_k     = '0;
                                n_row   = i_row;
                                n_nul   = (w_nk == '0);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                // one inner-product step per cycle
                w_issue = 1'b1;
                n_k     = r_k + t_k'(1);
                if (w_klast) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // hold until the far end of the chain has its result
                if (w_all_done) begin
                    n_state = ST_OUT;
                    n_j     = '0;
                end
            end
            ST_OUT: begin
                if (w_out_acc) begin
                    if (o_out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j = r_j + t_idx'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- A store
    assign w_waddr = AW'(AW'(i_row) * AW'(MAX_DIM)) + AW'(i_col);
    assign w_raddr = AW'(AW'(r_row) * AW'(MAX_DIM)) + AW'(r_k);

    always_ff @(posedge i_clk) begin
        if (w_awe) begin
            r_amem[w_waddr] <= w_sat_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_aq <= r_amem[w_raddr];
    end

    // token leaves alongside the registered A read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else begin
            r_tv <= w_issue;
            r_tf <= (r_k == '0);
            r_tl <= w_klast;
            r_tn <= r_nul;
            r_tk <= r_k;
        end
    end

    // ---------------------------------------------------------------- MAC chain
    for (genvar g = 0; g < DIM_LIM; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_tok_in[g] = '{vld: r_tv, first: r_tf, last: r_tl, nul: r_tn,
                                   k: r_tk, a: r_aq};
        end else begin : g_link
            assign w_tok_in[g] = w_tok_out[g-1];
        end

        if (g == DIM_LIM - 1) begin : g_tail
            assign w_res_in[g] = '0;
        end else begin : g_next
            assign w_res_in[g] = w_res_out[g+1];
        end

        assign w_ctl[g] = '{clr:   w_start,
                            shift: w_out_acc,
                            bwe:   w_bld && (i_col == t_idx'(g))};

        mmre_mac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_bk    (i_row[K_W-1:0]),
            .i_bdata (w_sat_val),
            .i_tok   (w_tok_in[g]),
            .o_tok   (w_tok_out[g]),
            .i_res   (w_res_in[g]),
            .o_res   (w_res_out[g]),
            .o_done  (w_done[g])
        );
    end

    // ---------------------------------------------------------------- result
    assign o_out_row   = r_row;
    assign o_out_col   = r_j;
    assign o_out_value = w_res_out[0];
    assign o_out_last  = (t_dim'(r_j) == w_nc - t_dim'(1));

    // ---------------------------------------------------------------- checks
    a_no_req_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request taken while results pending");

    a_row_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_last) |=> !o_out_valid)
        else $error("result after last of row");

    a_row_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_out_col == '0))
        else $error("result row does not start at column 0");

    a_chain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !w_all_done)
        else $error("cell chain reports done during issue");

endmodule
